### rtl/core/itoa_fmt_pkg.sv
// Package for the integer to ASCII formatter: codes, control word, microprogram and char table.
package itoa_fmt_pkg;

	localparam int DEFAULT_LONG_BITS      = 32;
	localparam int DEFAULT_POINTER_DIGITS = 8;

	localparam int BCD_DIGITS  = 20;
	localparam int NUM_DIGITS  = 22;
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 6;
	localparam int OUT_TDATA_W = 8;

	localparam logic [2:0] CMD_SDEC = 3'd0;
	localparam logic [2:0] CMD_UDEC = 3'd1;
	localparam logic [2:0] CMD_OCT  = 3'd2;
	localparam logic [2:0] CMD_HEX  = 3'd3;
	localparam logic [2:0] CMD_PTR  = 3'd4;

	localparam logic [2:0] SIZE_CHAR  = 3'd0;
	localparam logic [2:0] SIZE_SHORT = 3'd1;
	localparam logic [2:0] SIZE_INT   = 3'd2;
	localparam logic [2:0] SIZE_LONG  = 3'd3;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_X     = 8'h78;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_PREP   = 4'd1;
	localparam step_t ST_DAB    = 4'd2;
	localparam step_t ST_COUNT  = 4'd3;
	localparam step_t ST_PFX0   = 4'd4;
	localparam step_t ST_PFX1   = 4'd5;
	localparam step_t ST_PADCHK = 4'd6;
	localparam step_t ST_PAD    = 4'd7;
	localparam step_t ST_SGNCHK = 4'd8;
	localparam step_t ST_SIGN   = 4'd9;
	localparam step_t ST_DIGIT  = 4'd10;
	localparam step_t ST_DONE   = 4'd11;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	typedef enum logic [2:0] {
		CH_ZERO  = 3'd0,
		CH_X     = 3'd1,
		CH_PAD   = 3'd2,
		CH_MINUS = 3'd3,
		CH_DIGIT = 3'd4
	} chsel_t;

	typedef enum logic [2:0] {
		OP_NOP    = 3'd0,
		OP_LOAD   = 3'd1,
		OP_PREP   = 3'd2,
		OP_DAB    = 3'd3,
		OP_COUNT  = 3'd4,
		OP_PADDEC = 3'd5,
		OP_DIGDEC = 3'd6
	} dpop_t;

	typedef enum logic [3:0] {
		C_NEVER     = 4'd0,
		C_ALWAYS    = 4'd1,
		C_STAY_IDLE = 4'd2,
		C_NOT_DEC   = 4'd3,
		C_DAB_MORE  = 4'd4,
		C_NOT_PTR   = 4'd5,
		C_NO_PAD    = 4'd6,
		C_PAD_MORE  = 4'd7,
		C_NOT_NEG   = 4'd8,
		C_DIG_MORE  = 4'd9
	} cond_t;

	typedef struct packed {
		logic   take;
		logic   emit;
		chsel_t chsel;
		dpop_t  op;
		cond_t  cond;
		step_t  target;
	} uword_t;

	// Control store: jump to target when cond holds, else fall through.
	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		begin
			w = '{take: 1'b0, emit: 1'b0, chsel: CH_ZERO, op: OP_NOP, cond: C_NEVER,
				target: ST_IDLE};
			unique case (pc)
				ST_IDLE: begin
					w.take = 1'b1; w.op = OP_LOAD; w.cond = C_STAY_IDLE; w.target = ST_IDLE;
				end
				ST_PREP: begin
					w.op = OP_PREP; w.cond = C_NOT_DEC; w.target = ST_COUNT;
				end
				ST_DAB: begin
					w.op = OP_DAB; w.cond = C_DAB_MORE; w.target = ST_DAB;
				end
				ST_COUNT: begin
					w.op = OP_COUNT; w.cond = C_NOT_PTR; w.target = ST_PADCHK;
				end
				ST_PFX0: begin
					w.emit = 1'b1; w.chsel = CH_ZERO;
				end
				ST_PFX1: begin
					w.emit = 1'b1; w.chsel = CH_X;
				end
				ST_PADCHK: begin
					w.cond = C_NO_PAD; w.target = ST_SGNCHK;
				end
				ST_PAD: begin
					w.emit = 1'b1; w.chsel = CH_PAD; w.op = OP_PADDEC; w.cond = C_PAD_MORE;
					w.target = ST_PAD;
				end
				ST_SGNCHK: begin
					w.cond = C_NOT_NEG; w.target = ST_DIGIT;
				end
				ST_SIGN: begin
					w.emit = 1'b1; w.chsel = CH_MINUS;
				end
				ST_DIGIT: begin
					w.emit = 1'b1; w.chsel = CH_DIGIT; w.op = OP_DIGDEC; w.cond = C_DIG_MORE;
					w.target = ST_DIGIT;
				end
				default: begin
					w.cond = C_ALWAYS; w.target = ST_IDLE;
				end
			endcase
			return w;
		end
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		begin
			if (d < 4'd10) begin
				return ASCII_ZERO + {4'd0, d};
			end else begin
				return 8'h61 + {4'd0, d - 4'd10};
			end
		end
	endfunction

endpackage

### rtl/core/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: microcoded sequencer and its datapath.
//
// One request on the slave stream carries an integer argument, its size, the
// conversion, a minimum width and a zero-pad flag. The block answers with the
// formatted field on the master stream, one ASCII character per transfer, with
// tlast on the final digit. A request whose conversion code is above pointer
// is taken and dropped without output.
// A small control store sequences the work: load, truncate and negate, BCD
// conversion for decimal, digit count, then prefix, padding, sign and digits.
// Decimal requests shift one argument bit per cycle through the double-dabble
// loop (8, 16, 32, LONG_BITS or 64 bits); octal and hex read digits straight
// from the argument. The next request is taken once the sequencer is back at
// its first step.
// Characters leave through one output register; a stalled receiver holds the
// sequencer on its current step with no character lost.
// Reset returns the sequencer to its first step and empties the output register.
module integer_to_ascii_formatter_unit
	import itoa_fmt_pkg::*;
#(
	parameter int LONG_BITS      = DEFAULT_LONG_BITS,
	parameter int POINTER_DIGITS = DEFAULT_POINTER_DIGITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [63:0] value, [69:64] min_width, [70] zero_pad, [71] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [2:0] command, [5:3] size_code
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [7:0] out_char
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	step_t               pc_q;
	uword_t              uw;
	logic                fire;
	logic                jump;
	logic                in_accept;
	logic                out_free;

	logic [2:0]          cmd_in;
	logic [2:0]          size_in;
	logic [6:0]          bits_n;

	radix_t              radix_q;
	logic                sgn_q;
	logic                ptr_q;
	logic                neg_q;
	logic [6:0]          bits_q;
	logic [6:0]          cnt_q;
	logic [5:0]          width_q;
	logic [7:0]          pad_q;
	logic [63:0]         mag_q;
	logic [4*BCD_DIGITS-1:0] bcd_q;
	logic [5:0]          pad_cnt_q;
	logic [4:0]          dptr_q;

	logic [63:0]         mask;
	logic [63:0]         masked;
	logic                neg_n;
	logic [63:0]         mag_n;
	logic [4*BCD_DIGITS-1:0] bcd_adj;
	logic [65:0]         oct_bits;
	logic [4*NUM_DIGITS-1:0] dvec;
	logic [4:0]          hi_n;
	logic [4:0]          nd_n;
	logic [3:0]          cur_digit;
	logic [7:0]          char_n;

	logic                out_valid_q;
	logic [7:0]          out_char_q;
	logic                out_last_q;

	assign uw        = ucode(pc_q);
	assign cmd_in    = s_axis_tuser[2:0];
	assign size_in   = s_axis_tuser[5:3];
	assign out_free  = !out_valid_q || m_axis_tready;
	assign fire      = !uw.emit || out_free;
	assign in_accept = s_axis_tvalid && uw.take;

	assign s_axis_tready = uw.take;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		if (cmd_in == CMD_PTR) begin
			bits_n = 7'(LONG_BITS);
		end else begin
			unique case (size_in)
				SIZE_CHAR:  bits_n = 7'd8;
				SIZE_SHORT: bits_n = 7'd16;
				SIZE_INT:   bits_n = 7'd32;
				SIZE_LONG:  bits_n = 7'(LONG_BITS);
				default:    bits_n = 7'd64;
			endcase
		end
	end

	// Truncate to size and take the magnitude of a negative signed argument.
	always_comb begin
		for (int i = 0; i < 64; i++) begin
			mask[i] = (7'(i) < bits_q);
		end
		masked = mag_q & mask;
		neg_n  = sgn_q && masked[6'(bits_q - 7'd1)];
		mag_n  = neg_n ? ((~masked + 64'd1) & mask) : masked;
	end

	always_comb begin
		for (int d = 0; d < BCD_DIGITS; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
				: bcd_q[4*d +: 4];
		end
	end

	// Digits of the current radix, least significant first.
	always_comb begin
		oct_bits = {2'b00, mag_q};
		for (int k = 0; k < NUM_DIGITS; k++) begin
			unique case (radix_q)
				RADIX_DEC: dvec[4*k +: 4] = (k < BCD_DIGITS) ? bcd_q[(4*k) % (4*BCD_DIGITS) +: 4]
					: 4'd0;
				RADIX_OCT: dvec[4*k +: 4] = {1'b0, oct_bits[3*k +: 3]};
				RADIX_HEX: dvec[4*k +: 4] = (k < 16) ? mag_q[(4*k) % 64 +: 4] : 4'd0;
				default:   dvec[4*k +: 4] = 4'd0;
			endcase
		end
	end

	always_comb begin
		hi_n = 5'd0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (dvec[4*k +: 4] != 4'd0) begin
				hi_n = 5'(k);
			end
		end
		nd_n = hi_n + 5'd1 + {4'd0, neg_q};
	end

	assign cur_digit = dvec[{dptr_q, 2'b00} +: 4];

	always_comb begin
		unique case (uw.chsel)
			CH_ZERO:  char_n = ASCII_ZERO;
			CH_X:     char_n = ASCII_X;
			CH_PAD:   char_n = pad_q;
			CH_MINUS: char_n = ASCII_MINUS;
			CH_DIGIT: char_n = hex_char(cur_digit);
			default:  char_n = ASCII_SPACE;
		endcase
	end

	always_comb begin
		unique case (uw.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_STAY_IDLE: jump = !s_axis_tvalid || (cmd_in > CMD_PTR);
			C_NOT_DEC:   jump = (radix_q != RADIX_DEC);
			C_DAB_MORE:  jump = (cnt_q != 7'd1);
			C_NOT_PTR:   jump = !ptr_q;
			C_NO_PAD:    jump = (pad_cnt_q == 6'd0);
			C_PAD_MORE:  jump = (pad_cnt_q != 6'd1);
			C_NOT_NEG:   jump = !neg_q;
			C_DIG_MORE:  jump = (dptr_q != 5'd0);
			default:     jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (fire) begin
			pc_q <= jump ? uw.target : pc_q + step_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			unique case (uw.op)
				OP_NOP: begin
				end
				OP_LOAD: begin
					if (in_accept) begin
						mag_q  <= s_axis_tdata[63:0];
						bits_q <= bits_n;
						ptr_q  <= (cmd_in == CMD_PTR);
						sgn_q  <= (cmd_in == CMD_SDEC);
						if (cmd_in == CMD_SDEC || cmd_in == CMD_UDEC) begin
							radix_q <= RADIX_DEC;
						end else if (cmd_in == CMD_OCT) begin
							radix_q <= RADIX_OCT;
						end else begin
							radix_q <= RADIX_HEX;
						end
						if (cmd_in == CMD_PTR) begin
							width_q <= 6'(POINTER_DIGITS);
						end else begin
							width_q <= s_axis_tdata[69:64];
						end
						pad_q <= (cmd_in == CMD_PTR || s_axis_tdata[70]) ? ASCII_ZERO
							: ASCII_SPACE;
					end
				end
				OP_PREP: begin
					mag_q <= mag_n;
					neg_q <= neg_n;
					cnt_q <= bits_q;
					bcd_q <= '0;
				end
				OP_DAB: begin
					// Shift in the argument MSB first, from bit bits-1 down.
					bcd_q <= {bcd_adj[4*BCD_DIGITS-2:0], mag_q[6'(cnt_q - 7'd1)]};
					cnt_q <= cnt_q - 7'd1;
				end
				OP_COUNT: begin
					dptr_q    <= hi_n;
					pad_cnt_q <= (width_q > {1'b0, nd_n}) ? width_q - {1'b0, nd_n} : 6'd0;
				end
				OP_PADDEC: begin
					pad_cnt_q <= pad_cnt_q - 6'd1;
				end
				OP_DIGDEC: begin
					dptr_q <= dptr_q - 5'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.emit && out_free) begin
			out_char_q <= char_n;
			out_last_q <= (uw.chsel == CH_DIGIT) && (dptr_q == 5'd0);
		end
	end

	a_dab_decimal_only: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == ST_DAB |-> radix_q == RADIX_DEC && cnt_q != 7'd0)
		else $error("double-dabble step outside a decimal conversion");

	a_pad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == ST_PAD |-> pad_cnt_q != 6'd0)
		else $error("pad step entered with no pad left");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == ST_DIGIT |-> dptr_q < 5'(NUM_DIGITS))
		else $error("digit pointer beyond the digit vector");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && cmd_in <= CMD_PTR |=> pc_q == ST_PREP)
		else $error("accepted request did not start the program");

	a_last_from_digit: assert property (@(posedge clk) disable iff (!arst_n)
		uw.emit && out_free && pc_q != ST_DIGIT |=> !out_last_q)
		else $error("tlast raised on a non-digit character");

endmodule

### sim/tb.sv
// Self-checking testbench for the integer to ASCII formatter stream block.
`timescale 1ns / 1ps

module tb;
	import itoa_fmt_pkg::*;

	localparam int LONG_W         = DEFAULT_LONG_BITS;
	localparam int PTR_DIGITS     = DEFAULT_POINTER_DIGITS;
	localparam int MAX_FIELD      = 63;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int ITEMS_PER_PHASE = 39;

	// codes the package leaves unnamed
	localparam logic [2:0] CMD_RSVD5  = 3'd5;
	localparam logic [2:0] CMD_RSVD6  = 3'd6;
	localparam logic [2:0] CMD_RSVD7  = 3'd7;
	localparam logic [2:0] SIZE_LLONG = 3'd4;
	localparam logic [2:0] SIZE_RSVD5 = 3'd5;
	localparam logic [2:0] SIZE_RSVD7 = 3'd7;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} fmt_char_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [2:0]  size;
		logic [63:0] value;
		logic [5:0]  min_w;
		logic        zpad;
		logic        typed;
	} fmt_req_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	fmt_char_t pending_chars[$];
	fmt_req_t  dir_rows[$];
	string     dir_text[$];
	int        cur_row = -1;
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        errors = 0;
	int        quiet_cycles = 0;
	string     digit_set = "0123456789abcdef";

	integer_to_ascii_formatter_unit #(
		.LONG_BITS(LONG_W),
		.POINTER_DIGITS(PTR_DIGITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Queue the characters of one formatted field.
	function automatic void format_field(input logic [2:0] cmd, input logic [2:0] size,
		input logic [63:0] value, input logic [5:0] min_w, input logic zpad);
		int          nbits;
		int          field_w;
		logic [7:0]  pad_ch;
		logic [63:0] mask;
		logic [63:0] mag;
		logic [63:0] radix;
		logic        neg;
		logic [7:0]  digs[$];
		logic [7:0]  field[$];
		if (cmd > CMD_PTR) begin
			return;
		end
		field_w = min_w;
		pad_ch = zpad ? ASCII_ZERO : ASCII_SPACE;
		if (cmd == CMD_PTR) begin
			nbits = LONG_W;
			field_w = PTR_DIGITS;
			pad_ch = ASCII_ZERO;
		end else begin
			case (size)
				SIZE_CHAR:  nbits = 8;
				SIZE_SHORT: nbits = 16;
				SIZE_INT:   nbits = 32;
				SIZE_LONG:  nbits = LONG_W;
				default:    nbits = 64;
			endcase
		end
		mask = (nbits >= 64) ? '1 : ((64'd1 << nbits) - 64'd1);
		mag = value & mask;
		neg = (cmd == CMD_SDEC) && mag[nbits-1];
		if (neg) begin
			mag = (~mag + 64'd1) & mask;
		end
		if (cmd == CMD_SDEC || cmd == CMD_UDEC) begin
			radix = 64'd10;
		end else if (cmd == CMD_OCT) begin
			radix = 64'd8;
		end else begin
			radix = 64'd16;
		end
		do begin
			digs.push_front(digit_set[int'(mag % radix)]);
			mag = mag / radix;
		end while (mag != 64'd0);
		// sign sits between the padding and the digits
		if (neg) begin
			digs.push_front(ASCII_MINUS);
		end
		if (cmd == CMD_PTR) begin
			field.push_back(ASCII_ZERO);
			field.push_back(ASCII_X);
		end
		while (field_w > digs.size()) begin
			field.push_back(pad_ch);
			field_w--;
		end
		foreach (digs[i]) begin
			field.push_back(digs[i]);
		end
		while (field.size() > MAX_FIELD) begin
			void'(field.pop_back());
		end
		foreach (field[i]) begin
			pending_chars.push_back('{ch: field[i], last: (i == field.size() - 1)});
		end
	endfunction

	task automatic add_row(input logic [2:0] cmd, input logic [2:0] size,
		input logic [63:0] value, input logic [5:0] min_w, input logic zpad,
		input logic typed, input string text);
		dir_rows.push_back('{cmd: cmd, size: size, value: value, min_w: min_w, zpad: zpad,
			typed: typed});
		dir_text.push_back(text);
	endtask

	task automatic send_request(input logic [2:0] cmd, input logic [2:0] size,
		input logic [63:0] value, input logic [5:0] min_w, input logic zpad, input int row);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, zpad, min_w, value};
		s_axis_tuser <= {size, cmd};
		cur_row <= row;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Check characters, then queue what each accepted request must produce.
	always @(posedge clk) begin
		fmt_char_t want;
		string     txt;
		if (arst_n) begin
			quiet_cycles = quiet_cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				quiet_cycles = 0;
				if (pending_chars.size() == 0) begin
					$error("out_char: expected none, got %h", m_axis_tdata);
					errors++;
				end else begin
					want = pending_chars.pop_front();
					if (m_axis_tdata !== want.ch) begin
						$error("out_char: expected %h, got %h", want.ch, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %b, got %b", want.last, m_axis_tlast);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				quiet_cycles = 0;
				if (cur_row >= 0 && dir_rows[cur_row].typed) begin
					txt = dir_text[cur_row];
					for (int i = 0; i < txt.len(); i++) begin
						pending_chars.push_back('{ch: txt[i], last: (i == txt.len() - 1)});
					end
				end else begin
					format_field(s_axis_tuser[2:0], s_axis_tuser[5:3], s_axis_tdata[63:0],
						s_axis_tdata[69:64], s_axis_tdata[70]);
				end
			end
		end
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [2:0]  cmd;
		logic [2:0]  size;
		logic [63:0] value;
		logic [5:0]  min_w;
		int          pick;

		add_row(CMD_SDEC, SIZE_CHAR, 64'h80, 6'd0, 1'b0, 1'b1, "-128");
		add_row(CMD_SDEC, SIZE_CHAR, 64'h7f, 6'd0, 1'b0, 1'b1, "127");
		add_row(CMD_SDEC, SIZE_CHAR, 64'h0, 6'd0, 1'b1, 1'b1, "0");
		add_row(CMD_UDEC, SIZE_CHAR, 64'hffff_ffff_ffff_ffff, 6'd0, 1'b0, 1'b1, "255");
		add_row(CMD_SDEC, SIZE_SHORT, 64'hffff, 6'd6, 1'b1, 1'b1, "0000-1");
		add_row(CMD_SDEC, SIZE_LONG, 64'hffff_ffff, 6'd5, 1'b0, 1'b1, "   -1");
		add_row(CMD_SDEC, SIZE_INT, 64'h8000_0000, 6'd0, 1'b0, 1'b1, "-2147483648");
		add_row(CMD_UDEC, SIZE_INT, 64'h0, 6'd0, 1'b0, 1'b1, "0");
		add_row(CMD_SDEC, SIZE_LLONG, 64'h8000_0000_0000_0000, 6'd0, 1'b0, 1'b1,
			"-9223372036854775808");
		add_row(CMD_UDEC, SIZE_LLONG, 64'hffff_ffff_ffff_ffff, 6'd0, 1'b0, 1'b1,
			"18446744073709551615");
		add_row(CMD_OCT, SIZE_LLONG, 64'hffff_ffff_ffff_ffff, 6'd0, 1'b0, 1'b1,
			"1777777777777777777777");
		add_row(CMD_HEX, SIZE_LLONG, 64'hffff_ffff_ffff_ffff, 6'd0, 1'b0, 1'b1,
			"ffffffffffffffff");
		add_row(CMD_HEX, SIZE_INT, 64'h1234_5678_dead_beef, 6'd0, 1'b0, 1'b1, "deadbeef");
		add_row(CMD_HEX, SIZE_CHAR, 64'hab, 6'd4, 1'b0, 1'b1, "  ab");
		add_row(CMD_OCT, SIZE_INT, 64'h8, 6'd0, 1'b0, 1'b1, "10");
		add_row(CMD_PTR, SIZE_CHAR, 64'h0, 6'd0, 1'b0, 1'b1, "0x00000000");
		add_row(CMD_PTR, SIZE_LLONG, 64'h1234_5678_dead_beef, 6'd40, 1'b0, 1'b1, "0xdeadbeef");
		add_row(CMD_PTR, SIZE_RSVD7, 64'hffff_ffff_ffff_ffff, 6'd63, 1'b1, 1'b1, "0xffffffff");
		add_row(CMD_OCT, SIZE_SHORT, 64'h0, 6'd63, 1'b0, 1'b0, "");
		add_row(CMD_UDEC, SIZE_LONG, 64'hffff_ffff, 6'd63, 1'b1, 1'b0, "");
		// size codes past long long act as 64 bits
		add_row(CMD_SDEC, SIZE_RSVD7, 64'hffff_ffff_ffff_fffe, 6'd0, 1'b0, 1'b1, "-2");
		add_row(CMD_UDEC, SIZE_RSVD5, 64'h8000_0000_0000_0000, 6'd21, 1'b1, 1'b0, "");
		// conversion codes past pointer produce nothing
		add_row(CMD_RSVD5, SIZE_INT, 64'h1234, 6'd10, 1'b1, 1'b1, "");
		add_row(CMD_RSVD6, SIZE_CHAR, 64'hffff_ffff_ffff_ffff, 6'd63, 1'b0, 1'b1, "");
		add_row(CMD_RSVD7, SIZE_LLONG, 64'h0, 6'd0, 1'b0, 1'b1, "");

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].cmd, dir_rows[i].size, dir_rows[i].value,
				dir_rows[i].min_w, dir_rows[i].zpad, i);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 86; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 86; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				cmd = ($urandom_range(99) < 8) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
				size = ($urandom_range(99) < 10) ? 3'($urandom_range(5, 7)) :
					3'($urandom_range(0, 4));
				pick = $urandom_range(4);
				case (pick)
					0: value = {$urandom, $urandom};
					1: value = 64'($urandom_range(0, 999));
					2: value = -64'($urandom_range(1, 999));
					3: value = {$urandom, $urandom} | (64'd1 << $urandom_range(0, 63));
					default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
				endcase
				pick = $urandom_range(99);
				if (pick < 70) begin
					min_w = 6'($urandom_range(0, 12));
				end else if (pick < 90) begin
					min_w = 6'($urandom_range(13, 30));
				end else begin
					min_w = 6'($urandom_range(31, 63));
				end
				send_request(cmd, size, value, min_w, 1'($urandom_range(1)), -1);
			end
		end
		s_axis_tvalid <= 1'b0;
		// let the checker queue the last request first
		@(posedge clk);

		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_chars.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/itoa_fmt_pkg.sv
rtl/core/integer_to_ascii_formatter_unit.sv
sim/tb.sv
